@@ src/ym6fx_pkg.sv @@
// Shared types and constants for the YM6 effect frame decoder.
// No dependencies.
package ym6fx_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam int DRUM_COUNT_W = 6;
  localparam int CLOCK_W = 24;
  localparam int FREQ_W = 22;
  localparam int PREDIV_W = 8;
  localparam int COUNT_W = 8;
  localparam int DIVISOR_W = PREDIV_W + COUNT_W;
  localparam int QUOT_W = CLOCK_W;
  localparam int STEPS_PER_STAGE = 3;

  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 24'd2475600;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DRUM_COUNT = 1'b0,
    REG_CLOCK_HZ = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_SID = 2'd0,
    KIND_DRUM = 2'd1,
    KIND_SINUS_SID = 2'd2,
    KIND_BUZZER = 2'd3
  } kind_t;

  typedef logic [PREDIV_W-1:0] prediv_table_t [8];
  localparam prediv_table_t PREDIV_TABLE = '{
    8'd0, 8'd4, 8'd10, 8'd16, 8'd50, 8'd64, 8'd100, 8'd200
  };

  typedef struct packed {
    logic [7:0] effect_ctrl_a;
    logic [7:0] effect_ctrl_b;
    logic [7:0] prescale_reg_a;
    logic [7:0] level_voice_a;
    logic [7:0] level_voice_b;
    logic [7:0] level_voice_c;
    logic [7:0] reload_a;
    logic [7:0] reload_b;
  } frame_t;

  typedef struct packed {
    logic slot;
    logic active;
    logic [1:0] kind;
    logic [1:0] voice;
    logic [FREQ_W-1:0] frequency;
    logic [4:0] setting;
    logic last;
  } result_t;

endpackage

@@ src/ym6_effect_frame_decoder.sv @@
// YM6 effect frame decoder: two effect slots per frame, pipelined divider.
// Depends on ym6fx_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------
//  frame    | frame_valid/frame_ready  | frame_data (ym6fx_pkg::frame_t)
//  result   | result_valid/result_ready| result_data (ym6fx_pkg::result_t)
//  config   | cfg_we (no wait)         | cfg_index, cfg_data
//
// A frame is held in one register and sent down the pipe as two slot beats,
// A then B; the next frame is taken as slot B goes out, and every beat uses
// the single result channel. A slot passes, in order, the decode register,
// the 16-bit divisor multiply, the restoring divider stages and the result
// register.
// rst (synchronous) clears all valid bits and loads register reset values.
// One stall enable moves the whole pipe; a held result freezes every stage,
// so nothing is dropped or repeated, and bubbles stay in place while it waits.
module ym6_effect_frame_decoder #(
  parameter int STEPS_PER_STAGE = ym6fx_pkg::STEPS_PER_STAGE
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 frame_valid,
  output logic                                 frame_ready,
  input  ym6fx_pkg::frame_t                    frame_data,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output ym6fx_pkg::result_t                   result_data,
  input  logic                                 cfg_we,
  input  logic [ym6fx_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ym6fx_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ym6fx_pkg::*;

  localparam int DIV_STAGES = (QUOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Per-slot side data carried alongside the divider.
  typedef struct packed {
    logic slot;
    logic active;
    logic [1:0] kind;
    logic [1:0] voice;
    logic [4:0] setting;
  } slot_meta_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipe is idle; the block does not enforce it.
  logic [DRUM_COUNT_W-1:0] drum_count;
  logic [CLOCK_W-1:0]      clock_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      drum_count <= '0;
      clock_hz <= CLOCK_HZ_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DRUM_COUNT: drum_count <= cfg_data[DRUM_COUNT_W-1:0];
        REG_CLOCK_HZ: clock_hz <= cfg_data[CLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipe moves when the result register can take.
  logic en;
  assign en = !result_valid || result_ready;

  // ---------------------------------------------------------------------------
  // Frame register: holds one frame while slot A and then slot B go out.
  logic   fr_valid;
  logic   fr_phase;   // 0: slot A next, 1: slot B next
  frame_t fr;

  assign frame_ready = !fr_valid || (en && fr_phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
      fr_phase <= 1'b0;
    end else if (frame_valid && frame_ready) begin
      fr_valid <= 1'b1;
      fr_phase <= 1'b0;
    end else if (en && fr_valid) begin
      fr_phase <= !fr_phase;
      fr_valid <= !fr_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      fr <= frame_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode stage: pick the slot's bytes, voice, kind, setting, predivider.
  logic [7:0] dc_ctrl, dc_presc, dc_count, dc_level;
  logic [1:0] dc_vsel, dc_voice, dc_kind;
  logic [4:0] dc_setting;
  logic       dc_ok;

  always_comb begin
    dc_ctrl = fr_phase ? fr.effect_ctrl_b : fr.effect_ctrl_a;
    dc_presc = fr_phase ? fr.level_voice_a : fr.prescale_reg_a;
    dc_count = fr_phase ? fr.reload_b : fr.reload_a;
    dc_vsel = dc_ctrl[5:4];
    dc_kind = dc_ctrl[7:6];
    dc_voice = dc_vsel - 2'd1;
    case (dc_voice)
      2'd0: dc_level = fr.level_voice_a;
      2'd1: dc_level = fr.level_voice_b;
      default: dc_level = fr.level_voice_c;
    endcase
    if (dc_kind == KIND_DRUM) begin
      dc_setting = dc_level[4:0];
      dc_ok = ({1'b0, dc_level[4:0]} < drum_count);
    end else begin
      dc_setting = {1'b0, dc_level[3:0]};
      dc_ok = 1'b1;
    end
    dc_ok = dc_ok && (dc_vsel != 2'd0);
  end

  logic                d0_valid;
  slot_meta_t          d0_meta;
  logic [PREDIV_W-1:0] d0_prediv;
  logic [COUNT_W-1:0]  d0_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      d0_valid <= 1'b0;
    end else if (en) begin
      d0_valid <= fr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_meta.slot <= fr_phase;
      d0_meta.active <= dc_ok;
      d0_meta.kind <= dc_kind;
      d0_meta.voice <= dc_voice;
      d0_meta.setting <= dc_setting;
      d0_prediv <= PREDIV_TABLE[dc_presc[7:5]];
      d0_count <= dc_count;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: divisor = predivider * count (8x8). Zero divisor kills.
  logic                 m1_valid;
  slot_meta_t           m1_meta;
  logic [DIVISOR_W-1:0] m1_div;
  logic [DIVISOR_W-1:0] mul_div;

  assign mul_div = DIVISOR_W'(d0_prediv) * DIVISOR_W'(d0_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= d0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_meta.slot <= d0_meta.slot;
      m1_meta.active <= d0_meta.active && (mul_div != '0);
      m1_meta.kind <= d0_meta.kind;
      m1_meta.voice <= d0_meta.voice;
      m1_meta.setting <= d0_meta.setting;
      m1_div <= mul_div;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: clock_hz / divisor, STEPS_PER_STAGE quotient bits per
  // stage. qd shifts dividend bits out the top and quotient bits in below.
  logic                 dv_valid [DIV_STAGES];
  slot_meta_t           dv_meta  [DIV_STAGES];
  logic [DIVISOR_W-1:0] dv_div   [DIV_STAGES];
  logic [DIVISOR_W-1:0] dv_rem   [DIV_STAGES];
  logic [QUOT_W-1:0]    dv_qd    [DIV_STAGES];

  logic [DIVISOR_W-1:0] nx_rem [DIV_STAGES];
  logic [QUOT_W-1:0]    nx_qd  [DIV_STAGES];

  always_comb begin
    logic [DIVISOR_W-1:0] rem;
    logic [QUOT_W-1:0]    qd;
    logic [DIVISOR_W-1:0] dvs;
    logic [DIVISOR_W:0]   trial;
    logic                 ge;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem = '0;
        qd = clock_hz;
        dvs = m1_div;
      end else begin
        rem = dv_rem[s-1];
        qd = dv_qd[s-1];
        dvs = dv_div[s-1];
      end
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (s * STEPS_PER_STAGE + j < QUOT_W) begin
          trial = {rem, qd[QUOT_W-1]};
          ge = (trial >= {1'b0, dvs});
          if (ge) begin
            trial = trial - {1'b0, dvs};
          end
          rem = trial[DIVISOR_W-1:0];
          qd = {qd[QUOT_W-2:0], ge};
        end
      end
      nx_rem[s] = rem;
      nx_qd[s] = qd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_valid[s] <= 1'b0;
      end
    end else if (en) begin
      dv_valid[0] <= m1_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv_valid[s] <= dv_valid[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_meta[0] <= m1_meta;
      dv_div[0] <= m1_div;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv_meta[s] <= dv_meta[s-1];
        dv_div[s] <= dv_div[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv_rem[s] <= nx_rem[s];
        dv_qd[s] <= nx_qd[s];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. Inactive slots report zero kind, voice, setting and frequency.
  slot_meta_t fin_meta;
  logic       fin_act;

  assign fin_meta = dv_meta[DIV_STAGES-1];
  assign fin_act = fin_meta.active;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv_valid[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_data.slot <= fin_meta.slot;
      result_data.last <= fin_meta.slot;
      result_data.active <= fin_act;
      result_data.kind <= fin_act ? fin_meta.kind : 2'd0;
      result_data.voice <= fin_act ? fin_meta.voice : 2'd0;
      result_data.setting <= fin_act ? fin_meta.setting : 5'd0;
      result_data.frequency <= fin_act ? dv_qd[DIV_STAGES-1][FREQ_W-1:0] : '0;
    end
  end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for ym6_effect_frame_decoder: directed and random YM6 frames,
// with per-slot expected results kept by a small scoreboard class.
// Depends on ym6fx_pkg and the decoder RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ym6fx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;  // far above the slowest legal run
  localparam int unsigned LONG_HOLD = 160;       // result stall that backs up the pipe
  localparam int unsigned TAIL_CYCLES = 40;      // longer than the decoder latency
  localparam int unsigned MAX_REPORTS = 10;

  // Scoreboard: shadow copy of the two registers, per-slot expected results.
  class slot_result_board;
    logic [5:0]  drum_limit;
    logic [23:0] timer_clock;
    result_t     slot_results_due[$];
    int unsigned bad_results;

    function new();
      drum_limit = '0;
      timer_clock = CLOCK_HZ_RESET;
      bad_results = 0;
    endfunction

    function void set_register(cfg_reg_t which, logic [23:0] value);
      case (which)
        REG_DRUM_COUNT: drum_limit = value[5:0];
        REG_CLOCK_HZ:   timer_clock = value;
        default:        ;
      endcase
    endfunction

    // Decode one effect slot of a frame; slot B takes its predivider from
    // the voice 0 level byte.
    function result_t predict_slot(bit is_b, frame_t f);
      result_t     r;
      logic [7:0]  ctrl, presc, count, lvl;
      logic [1:0]  vcode;
      logic [7:0]  step;
      logic [15:0] divisor;
      logic [23:0] quotient;
      logic [4:0]  setting;
      kind_t       k;
      ctrl  = is_b ? f.effect_ctrl_b : f.effect_ctrl_a;
      presc = is_b ? f.level_voice_a : f.prescale_reg_a;
      count = is_b ? f.reload_b : f.reload_a;
      vcode = ctrl[5:4];
      k = kind_t'(ctrl[7:6]);
      case (presc[7:5])
        3'd0: step = 8'd0;
        3'd1: step = 8'd4;
        3'd2: step = 8'd10;
        3'd3: step = 8'd16;
        3'd4: step = 8'd50;
        3'd5: step = 8'd64;
        3'd6: step = 8'd100;
        default: step = 8'd200;
      endcase
      divisor = {8'd0, step} * {8'd0, count};
      case (vcode)
        2'd1: lvl = f.level_voice_a;
        2'd2: lvl = f.level_voice_b;
        default: lvl = f.level_voice_c;
      endcase
      setting = (k == KIND_DRUM) ? lvl[4:0] : {1'b0, lvl[3:0]};
      r = '0;
      r.slot = is_b;
      r.last = is_b;
      if (vcode != 2'd0 && divisor != 16'd0 &&
          (k != KIND_DRUM || {1'b0, setting} < drum_limit)) begin
        quotient = timer_clock / {8'd0, divisor};
        r.active = 1'b1;
        r.kind = k;
        r.voice = vcode - 2'd1;
        r.frequency = quotient[FREQ_W-1:0];
        r.setting = setting;
      end
      return r;
    endfunction

    function void note_frame(frame_t f);
      slot_results_due.push_back(predict_slot(1'b0, f));
      slot_results_due.push_back(predict_slot(1'b1, f));
    endfunction

    function int unsigned pending();
      return slot_results_due.size();
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      bad_results++;
      if (bad_results <= MAX_REPORTS)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (slot_results_due.size() == 0) begin
        report("result beat with nothing due", 32'd0, {10'd0, got.frequency});
        return;
      end
      want = slot_results_due.pop_front();
      if (got.slot !== want.slot) report("slot", 32'(want.slot), 32'(got.slot));
      if (got.active !== want.active) report("active", 32'(want.active), 32'(got.active));
      if (got.kind !== want.kind) report("kind", 32'(want.kind), 32'(got.kind));
      if (got.voice !== want.voice) report("voice", 32'(want.voice), 32'(got.voice));
      if (got.frequency !== want.frequency)
        report("frequency", 32'(want.frequency), 32'(got.frequency));
      if (got.setting !== want.setting)
        report("setting", 32'(want.setting), 32'(got.setting));
      if (got.last !== want.last) report("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   frame_valid = 1'b0;
  logic                   frame_ready;
  frame_t                 frame_data = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Idle modes per phase, and the one-shot request for a long result stall.
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_results = 1'b0;

  slot_result_board slots = new();

  ym6_effect_frame_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_data   (frame_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offer one frame beat. Valid stays high after the accept so that a
  // back-to-back beat never drops it; callers must send the next frame or
  // call settle() in the same time step the previous send returned.
  task automatic send_frame(input frame_t f);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_data <= f;
    do @(posedge clk); while (!frame_ready);
    slots.note_frame(f);
  endtask

  // Stop offering and wait until every due slot result has come back.
  task automatic settle();
    frame_valid <= 1'b0;
    while (slots.pending() != 0) @(posedge clk);
  endtask

  // One-cycle register write; the extra edge keeps back-to-back writes
  // from lowering and raising cfg_we in the same step.
  task automatic write_reg(input cfg_reg_t which, input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    slots.set_register(which, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stall before each beat, or one long hold on request.
  initial begin : result_sink
    int unsigned stall;
    wait (rst == 1'b0);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = rx_idle ? $urandom_range(0, 13) : 0;
      end
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      slots.check_result(result_data);
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    frame_t      f;
    logic [23:0] clk_val;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset values: drum count 0 rejects every DigiDrum slot.
    send_frame('0);                                        // no voice, zero divisors
    send_frame('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_frame('{8'h50, 8'h60, 8'h20, 8'h20, 8'h01, 8'h00, 8'h05, 8'h09});
    settle();

    // Widest drum set, fastest clock.
    write_reg(REG_DRUM_COUNT, 24'd32);
    write_reg(REG_CLOCK_HZ, 24'd16000000);
    // Highest frequency: predivider 4, count 1, on both slots.
    send_frame('{8'h10, 8'h20, 8'h20, 8'h20, 8'h0C, 8'h03, 8'h01, 8'h01});
    // Every kind on every voice, two combinations per frame.
    for (int i = 0; i < 12; i += 2) begin
      f = '{8'({2'(i / 3), 2'(i % 3 + 1), 4'h5}), 8'({2'((i + 1) / 3), 2'((i + 1) % 3 + 1), 4'hA}),
            8'h7E, 8'hB3, 8'h1F, 8'h0A, 8'h2D, 8'h80};
      send_frame(f);
    end
    // Voice code zero with noise elsewhere; predivider select 0; count 0.
    send_frame('{8'hC5, 8'h0F, 8'hE0, 8'hFF, 8'h0E, 8'h0D, 8'h11, 8'h22});
    send_frame('{8'h10, 8'h20, 8'h1F, 8'h60, 8'h04, 8'h05, 8'h40, 8'h00});
    // Lowest frequency: predivider 200, count 255.
    send_frame('{8'h70, 8'hB0, 8'hE0, 8'hE0, 8'h07, 8'h1C, 8'hFF, 8'hFF});
    settle();

    // Drum index right at and just below the count; clock 1 gives 0 Hz.
    write_reg(REG_DRUM_COUNT, 24'd16);
    write_reg(REG_CLOCK_HZ, 24'd1);
    send_frame('{8'h50, 8'h60, 8'h20, 8'h30, 8'h10, 8'h0F, 8'h01, 8'h01});
    send_frame('{8'h60, 8'h50, 8'h40, 8'h2F, 8'h0F, 8'h10, 8'h03, 8'h02});
    settle();

    // Clock of zero: active slots report frequency 0.
    write_reg(REG_CLOCK_HZ, 24'd0);
    send_frame('{8'h10, 8'hF0, 8'h20, 8'h20, 8'h03, 8'h0F, 8'h01, 8'h01});
    send_frame('{8'h90, 8'h70, 8'hE0, 8'hFF, 8'h0A, 8'h1F, 8'hFF, 8'h80});
    settle();

    // Random phases: each takes a new register setting and idle mix.
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 3))
        0: clk_val = 24'd16000000;
        1: clk_val = 24'($urandom_range(1, 5000));
        2: clk_val = CLOCK_HZ_RESET;
        default: clk_val = 24'($urandom_range(1, 16000000));
      endcase
      write_reg(REG_DRUM_COUNT, (p == 0) ? 24'd0 : (p == 1) ? 24'd32 :
                24'($urandom_range(0, 32)));
      write_reg(REG_CLOCK_HZ, clk_val);
      // Phase 0 runs flat out on both sides; phase 3 backs up the pipe.
      tx_idle = (p != 0 && p != 3) && ($urandom_range(0, 3) != 0);
      rx_idle = (p != 0) && ($urandom_range(0, 3) != 0);
      if (p == 3)
        hold_results = 1'b1;
      for (int n = 0; n < 104; n++) begin
        f = frame_t'({$urandom, $urandom});
        // Mostly slots that select a voice; short counts reach high rates.
        if ($urandom_range(0, 4) != 0 && f.effect_ctrl_a[5:4] == 2'd0)
          f.effect_ctrl_a[5:4] = 2'($urandom_range(1, 3));
        if ($urandom_range(0, 4) != 0 && f.effect_ctrl_b[5:4] == 2'd0)
          f.effect_ctrl_b[5:4] = 2'($urandom_range(1, 3));
        if ($urandom_range(0, 5) == 0)
          f.reload_a = 8'($urandom_range(0, 2));
        if ($urandom_range(0, 5) == 0)
          f.reload_b = 8'($urandom_range(0, 2));
        send_frame(f);
      end
      settle();
    end

    // Catch any stray beat after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (slots.bad_results == 0 && slots.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
